// ----- rtl/json_frame_limit_scanner_core_assert.svh -----
// assertion macros for the json frame limit scanner
// expects signals named clk and rst in the including module
`ifndef JSON_FRAME_LIMIT_SCANNER_CORE_ASSERT_SVH
`define JSON_FRAME_LIMIT_SCANNER_CORE_ASSERT_SVH

// same-cycle implication, ignored during reset
`define JFLS_ASSERT_NOW(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("jfls assertion failed");

// next-cycle implication, ignored during reset
`define JFLS_ASSERT_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("jfls assertion failed");

`endif

// ----- rtl/jfls_pkg.sv -----
// shared types and constants for the json frame limit scanner
// no dependencies
package jfls_pkg;

  // character codes that steer the scan
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // limit register widths
  localparam int FRAME_W  = 24;
  localparam int DEPTH_W  = 8;
  localparam int NODES_W  = 20;
  localparam int STRING_W = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  // limit register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_FRAME_BYTES  = 2'd0,
    REG_MAX_DEPTH        = 2'd1,
    REG_MAX_NODES        = 2'd2,
    REG_MAX_STRING_BYTES = 2'd3
  } jfls_reg_t;

  // reset values of the limits
  localparam logic [FRAME_W-1:0]  RST_MAX_FRAME_BYTES  = 24'd1048576;
  localparam logic [DEPTH_W-1:0]  RST_MAX_DEPTH        = 8'd64;
  localparam logic [NODES_W-1:0]  RST_MAX_NODES        = 20'd65536;
  localparam logic [STRING_W-1:0] RST_MAX_STRING_BYTES = 24'd1048576;

  // current limits handed to the scanner
  typedef struct packed {
    logic [FRAME_W-1:0]  max_frame_bytes;
    logic [DEPTH_W-1:0]  max_depth;
    logic [NODES_W-1:0]  max_nodes;
    logic [STRING_W-1:0] max_string_bytes;
  } jfls_limits_t;

endpackage

// ----- rtl/jfls_scan.sv -----
// per-byte scan state and limit checks for one frame
// depends on jfls_pkg
module jfls_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat,           // input beat accepted this cycle
  input  logic [7:0]          data_byte,
  input  logic                byte_present,
  input  logic                frame_end,
  input  jfls_pkg::jfls_limits_t limits,
  output logic                res_valid,
  output logic                res_bit
);

  // frame state
  logic        in_quotes, in_quotes_next;
  logic        after_escape, after_escape_next;
  logic        in_primitive, in_primitive_next;
  logic [8:0]  nest_level, nest_level_next;
  logic [20:0] node_count, node_count_next;
  logic [24:0] quoted_byte_count, quoted_byte_count_next;
  logic [24:0] frame_byte_count, frame_byte_count_next;
  logic        limit_failed, limit_failed_next;

  logic        scan;
  logic        is_blank;
  logic [24:0] fb_inc, qb_inc;
  logic [20:0] nc_inc;
  logic [8:0]  nl_inc;
  logic        frame_over, quoted_over, node_over, depth_over;

  // incremented counts and their limit compares
  assign scan    = beat && byte_present && !limit_failed;
  assign fb_inc  = frame_byte_count + 25'd1;
  assign qb_inc  = quoted_byte_count + 25'd1;
  assign nc_inc  = node_count + 21'd1;
  assign nl_inc  = nest_level + 9'd1;
  assign frame_over  = fb_inc > {1'b0, limits.max_frame_bytes};
  assign quoted_over = qb_inc > {1'b0, limits.max_string_bytes};
  assign node_over   = nc_inc > {1'b0, limits.max_nodes};
  assign depth_over  = nl_inc > {1'b0, limits.max_depth};
  assign is_blank    = (data_byte == jfls_pkg::CH_SPACE) ||
                       ((data_byte >= jfls_pkg::CH_TAB) && (data_byte <= jfls_pkg::CH_CR));

  // next state for one byte
  always_comb begin
    in_quotes_next         = in_quotes;
    after_escape_next      = after_escape;
    in_primitive_next      = in_primitive;
    nest_level_next        = nest_level;
    node_count_next        = node_count;
    quoted_byte_count_next = quoted_byte_count;
    frame_byte_count_next  = frame_byte_count;
    limit_failed_next      = limit_failed;
    if (scan) begin
      frame_byte_count_next = fb_inc;
      if (frame_over) begin
        limit_failed_next = 1'b1;
      end else if (in_quotes) begin
        // string body: escape pair and plain bytes count, closing quote does not
        if (after_escape || data_byte != jfls_pkg::CH_QUOTE) begin
          after_escape_next      = !after_escape && (data_byte == jfls_pkg::CH_BSLASH);
          quoted_byte_count_next = qb_inc;
          if (quoted_over) begin
            limit_failed_next = 1'b1;
          end
        end else begin
          in_quotes_next = 1'b0;
        end
      end else if (data_byte == jfls_pkg::CH_QUOTE) begin
        in_quotes_next    = 1'b1;
        in_primitive_next = 1'b0;
        node_count_next   = nc_inc;
        if (node_over) begin
          limit_failed_next = 1'b1;
        end
      end else if (data_byte == jfls_pkg::CH_LBRACE || data_byte == jfls_pkg::CH_LBRACK) begin
        in_primitive_next = 1'b0;
        nest_level_next   = nl_inc;
        if (depth_over) begin
          limit_failed_next = 1'b1;
        end else begin
          node_count_next = nc_inc;
          if (node_over) begin
            limit_failed_next = 1'b1;
          end
        end
      end else if (data_byte == jfls_pkg::CH_RBRACE || data_byte == jfls_pkg::CH_RBRACK) begin
        in_primitive_next = 1'b0;
        if (nest_level != 9'd0) begin
          nest_level_next = nest_level - 9'd1;
        end
      end else if (data_byte == jfls_pkg::CH_COMMA || data_byte == jfls_pkg::CH_COLON ||
                   is_blank) begin
        in_primitive_next = 1'b0;
      end else if (!in_primitive) begin
        // first byte of a bare token
        in_primitive_next = 1'b1;
        node_count_next   = nc_inc;
        if (node_over) begin
          limit_failed_next = 1'b1;
        end
      end
    end
  end

  // verdict on the last beat of a frame
  assign res_valid = beat && frame_end;
  assign res_bit   = !limit_failed_next;

  // state register, cleared at reset and after each frame
  always_ff @(posedge clk) begin
    if (rst || (beat && frame_end)) begin
      in_quotes         <= 1'b0;
      after_escape      <= 1'b0;
      in_primitive      <= 1'b0;
      nest_level        <= '0;
      node_count        <= '0;
      quoted_byte_count <= '0;
      frame_byte_count  <= '0;
      limit_failed      <= 1'b0;
    end else begin
      in_quotes         <= in_quotes_next;
      after_escape      <= after_escape_next;
      in_primitive      <= in_primitive_next;
      nest_level        <= nest_level_next;
      node_count        <= node_count_next;
      quoted_byte_count <= quoted_byte_count_next;
      frame_byte_count  <= frame_byte_count_next;
      limit_failed      <= limit_failed_next;
    end
  end

endmodule

// ----- rtl/json_frame_limit_scanner_core.sv -----
// top level of the json frame limit scanner: stream ports, limit registers, result buffer
// depends on jfls_pkg, jfls_scan and json_frame_limit_scanner_core_assert.svh

// Scans a JSON frame one byte per beat and checks it against four limits: frame
// bytes, nesting depth, node count and quoted bytes summed over the frame. One byte
// is taken every clock while s_tready is high; each beat goes through a single layer
// of compare and add logic into the frame state registers, and the tlast beat gives
// one verdict beat (m_tdata[0] = 1 when every limit was met), held in the output
// register, or in the skid entry when that is full. A two-entry output buffer lets
// input beats keep flowing while a verdict waits for m_tready; s_tready only drops
// when both entries are held. A beat with s_tuser low carries no byte: with tlast
// it closes the frame, without it nothing happens. The user must write limits via
// cfg_we/cfg_index/cfg_wdata while no frame is in progress; this is not enforced.
module json_frame_limit_scanner_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_present
  input  logic        s_tlast,   // frame_end
  // verdict stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] within_bounds, [7:1] zero
  // limit registers
  input  logic        cfg_we,
  input  logic [jfls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jfls_pkg::CFG_W-1:0]     cfg_wdata
);

  jfls_pkg::jfls_limits_t limits;
  logic beat;
  logic res_valid, res_bit;
  logic out_valid, out_bit;
  logic skid_valid, skid_bit;
  logic out_free;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.max_frame_bytes  <= jfls_pkg::RST_MAX_FRAME_BYTES;
      limits.max_depth        <= jfls_pkg::RST_MAX_DEPTH;
      limits.max_nodes        <= jfls_pkg::RST_MAX_NODES;
      limits.max_string_bytes <= jfls_pkg::RST_MAX_STRING_BYTES;
    end else if (cfg_we) begin
      unique case (jfls_pkg::jfls_reg_t'(cfg_index))
        jfls_pkg::REG_MAX_FRAME_BYTES: begin
          limits.max_frame_bytes <= cfg_wdata[jfls_pkg::FRAME_W-1:0];
        end
        jfls_pkg::REG_MAX_DEPTH: begin
          limits.max_depth <= cfg_wdata[jfls_pkg::DEPTH_W-1:0];
        end
        jfls_pkg::REG_MAX_NODES: begin
          limits.max_nodes <= cfg_wdata[jfls_pkg::NODES_W-1:0];
        end
        jfls_pkg::REG_MAX_STRING_BYTES: begin
          limits.max_string_bytes <= cfg_wdata[jfls_pkg::STRING_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // input handshake
  assign s_tready = !skid_valid;
  assign beat     = s_tvalid && s_tready;

  jfls_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .data_byte    (s_tdata),
    .byte_present (s_tuser),
    .frame_end    (s_tlast),
    .limits       (limits),
    .res_valid    (res_valid),
    .res_bit      (res_bit)
  );

  // verdict register with skid entry behind it
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_bit <= skid_valid ? skid_bit : res_bit;
    end
    if (!out_free && res_valid) begin
      skid_bit <= res_bit;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_bit};

  // checks on the result buffer
  `include "json_frame_limit_scanner_core_assert.svh"

  `JFLS_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `JFLS_ASSERT_NEXT(a_stall_fills_skid, res_valid && out_valid && !m_tready, skid_valid)
  `JFLS_ASSERT_NEXT(a_skid_moves_up, skid_valid && m_tready, out_valid && !skid_valid)

endmodule
